// ===== rtl/core/afr_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// afr_pkg
// Shared types and constants for the affine rotate pixel fetch block.
// ---------------------------------------------------------------------------
package afr_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;

	localparam int COORD_W = 8;                 // pos_x / pos_y width
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int ADDR_W  = COL_W + ROW_W;     // store address {row, col}
	localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
	localparam int DIM_W   = 9;                 // source_width / source_height
	localparam int COEF_W  = 32;
	localparam int PIX_W   = 32;
	localparam int HALF_W  = COORD_W + 1;       // 2*pos+1
	localparam int PROD_W  = COEF_W + HALF_W + 1;
	localparam int SUM_W   = PROD_W + 2;
	localparam int FRAC_W  = 17;                // sum is in units of 2^-17
	localparam int SRC_W   = SUM_W - FRAC_W;    // floored source coordinate

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_XX  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_XY  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_YX  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_YY  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_W    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_H    = 3'd7;

	localparam logic CMD_STORE = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	localparam logic [COEF_W-1:0] COEF_ONE   = 32'h0001_0000;
	localparam logic [DIM_W-1:0]  DIM_RESET  = 9'd256;
	localparam logic [7:0]        ALPHA_FULL = 8'd255;

	typedef struct packed {
		logic               command;
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic [7:0]         chan0_in;
		logic [7:0]         chan1_in;
		logic [7:0]         chan2_in;
		logic [7:0]         chan3_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] chan0_out;
		logic [7:0] chan1_out;
		logic [7:0] chan2_out;
		logic [7:0] chan3_out;
		logic       outside;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;    // latch fetch coordinates
		logic store_we;   // write pixel of the accepted store request
		logic mul_en;
		logic sum_en;
		logic rd_en;
		logic out_load;
	} dp_cmd_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] lim);
		return (v > lim) ? lim : v;
	endfunction

endpackage

// ===== rtl/core/afr_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// afr_ctrl
// Sequencer: accepts requests, steps a fetch through multiply, sum, store
// read and output load, and owns the output valid flag.
// ---------------------------------------------------------------------------
module afr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            in_cmd,
	output logic            out_valid,
	input  logic            out_ready,
	output afr_pkg::dp_cmd_t cmd
);
	import afr_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_SUM  = 3'd2;
	localparam logic [2:0] ST_READ = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_cmd == CMD_FETCH) begin
						cmd.capture = 1'b1;
						state_d     = ST_MUL;
					end else begin
						cmd.store_we = 1'b1;
					end
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum_en = 1'b1;
				state_d    = ST_READ;
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_OUT;
			end
			ST_OUT: begin
				// wait for the output register to free up
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

`ifndef ASSERT_OFF
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("output register overwritten while full");

	a_fetch_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_cmd == CMD_FETCH) |=> (state_q == ST_MUL))
		else $error("fetch request did not start the sequence");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !(cmd.mul_en || cmd.sum_en || cmd.rd_en || cmd.out_load))
		else $error("datapath busy while accepting requests");

	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_OUT))
		else $error("result raised outside the output step");
`endif

endmodule

// ===== rtl/core/afr_dpath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// afr_dpath
// Configuration registers, frame store, inverse mapping arithmetic and the
// output register.
// ---------------------------------------------------------------------------
module afr_dpath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [afr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [afr_pkg::COEF_W-1:0]       cfg_wdata,
	input  afr_pkg::in_item_t                in_data,
	input  afr_pkg::dp_cmd_t                 cmd,
	output afr_pkg::out_item_t               out_data
);
	import afr_pkg::*;

	logic signed [COEF_W-1:0] coef_xx_q, coef_xy_q, offset_x_q;
	logic signed [COEF_W-1:0] coef_yx_q, coef_yy_q, offset_y_q;
	logic [DIM_W-1:0]         src_w_q, src_h_q;

	logic [PIX_W-1:0] pixel_mem [0:DEPTH-1];

	logic [COORD_W-1:0]       pos_x_q, pos_y_q;
	logic signed [PROD_W-1:0] prod_xx_q, prod_xy_q, prod_yx_q, prod_yy_q;
	logic signed [PROD_W-1:0] prod_xx, prod_xy, prod_yx, prod_yy;
	logic signed [SUM_W-1:0]  sum_x, sum_y;
	logic signed [SRC_W-1:0]  src_x, src_y;
	logic [DIM_W-1:0]         w_eff, h_eff;
	logic                     out_x, out_y;
	logic [ADDR_W-1:0]        addr_q, wr_addr;
	logic                     outside_q, outside_s2;
	logic [PIX_W-1:0]         rd_data_q;
	logic signed [HALF_W:0]   half_x, half_y;
	logic                     store_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_xx_q  <= COEF_ONE;
			coef_xy_q  <= '0;
			offset_x_q <= '0;
			coef_yx_q  <= '0;
			coef_yy_q  <= COEF_ONE;
			offset_y_q <= '0;
			src_w_q    <= DIM_RESET;
			src_h_q    <= DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COEF_XX:  coef_xx_q  <= cfg_wdata;
				REG_COEF_XY:  coef_xy_q  <= cfg_wdata;
				REG_OFFSET_X: offset_x_q <= cfg_wdata;
				REG_COEF_YX:  coef_yx_q  <= cfg_wdata;
				REG_COEF_YY:  coef_yy_q  <= cfg_wdata;
				REG_OFFSET_Y: offset_y_q <= cfg_wdata;
				REG_SRC_W:    src_w_q    <= cfg_wdata[DIM_W-1:0];
				REG_SRC_H:    src_h_q    <= cfg_wdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// frame store write
	assign store_ok = ({1'b0, in_data.pos_x} < DIM_W'(MAX_WIDTH)) &&
		({1'b0, in_data.pos_y} < DIM_W'(MAX_HEIGHT));
	assign wr_addr  = {in_data.pos_y[ROW_W-1:0], in_data.pos_x[COL_W-1:0]};

	always_ff @(posedge clk) begin
		if (cmd.store_we && store_ok)
			pixel_mem[wr_addr] <= {in_data.chan3_in, in_data.chan2_in,
				in_data.chan1_in, in_data.chan0_in};
		if (cmd.rd_en)
			rd_data_q <= pixel_mem[addr_q];
	end

	// pixel center as (2p+1)/2, kept as a positive signed value
	assign half_x = {1'b0, pos_x_q, 1'b1};
	assign half_y = {1'b0, pos_y_q, 1'b1};

	assign prod_xx = coef_xx_q * half_x;
	assign prod_xy = coef_xy_q * half_y;
	assign prod_yx = coef_yx_q * half_x;
	assign prod_yy = coef_yy_q * half_y;

	assign sum_x = SUM_W'(prod_xx_q) + SUM_W'(prod_xy_q) + (SUM_W'(offset_x_q) <<< 1);
	assign sum_y = SUM_W'(prod_yx_q) + SUM_W'(prod_yy_q) + (SUM_W'(offset_y_q) <<< 1);

	// arithmetic shift right floors toward minus infinity
	assign src_x = sum_x[SUM_W-1:FRAC_W];
	assign src_y = sum_y[SUM_W-1:FRAC_W];

	assign w_eff = clamp_dim(src_w_q, DIM_W'(MAX_WIDTH));
	assign h_eff = clamp_dim(src_h_q, DIM_W'(MAX_HEIGHT));

	// any bit at or above the column width means negative or past the frame
	assign out_x = (src_x[SRC_W-1:COL_W] != '0) ||
		(DIM_W'(src_x[COL_W-1:0]) >= w_eff);
	assign out_y = (src_y[SRC_W-1:ROW_W] != '0) ||
		(DIM_W'(src_y[ROW_W-1:0]) >= h_eff);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pos_x_q <= in_data.pos_x;
			pos_y_q <= in_data.pos_y;
		end
		if (cmd.mul_en) begin
			prod_xx_q <= prod_xx;
			prod_xy_q <= prod_xy;
			prod_yx_q <= prod_yx;
			prod_yy_q <= prod_yy;
		end
		if (cmd.sum_en) begin
			addr_q    <= {src_y[ROW_W-1:0], src_x[COL_W-1:0]};
			outside_q <= out_x || out_y;
		end
		if (cmd.rd_en)
			outside_s2 <= outside_q;
		if (cmd.out_load) begin
			if (outside_s2) begin
				out_data <= '{chan0_out: 8'd0, chan1_out: 8'd0, chan2_out: 8'd0,
					chan3_out: ALPHA_FULL, outside: 1'b1};
			end else begin
				out_data <= '{chan0_out: rd_data_q[7:0], chan1_out: rd_data_q[15:8],
					chan2_out: rd_data_q[23:16], chan3_out: rd_data_q[31:24],
					outside: 1'b0};
			end
		end
	end

endmodule

// ===== rtl/core/affine_rotate_pixel_fetch.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// affine_rotate_pixel_fetch
// Source frame store with inverse affine nearest-neighbor pixel fetch.
// Store request: written to the frame store in the cycle it is accepted.
// Fetch request: stepped through the multiply, sum, store read and output
//   load steps; no new request is taken until the output load is done.
// A new request is taken while a finished result waits in the output register.
// Reset (arst_n low) clears control and config; the frame store is not cleared.
// ---------------------------------------------------------------------------
module affine_rotate_pixel_fetch (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [afr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [afr_pkg::COEF_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  afr_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output afr_pkg::out_item_t            out_data
);
	import afr_pkg::*;

	dp_cmd_t cmd;

	afr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_cmd    (in_data.command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	afr_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.out_data  (out_data)
	);

endmodule

// ===== verif/affine_rotate_pixel_fetch_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// affine_rotate_pixel_fetch_test
// Self-checking bench for the affine pixel fetch block. Pixels are stored and
// fetched back through a set of mappings (identity, shifts, turns, scaling,
// degenerate and extreme matrices, clipped and oversized frames). Every fetch
// result is checked against a local prediction of the map and frame contents.
// ---------------------------------------------------------------------------
module affine_rotate_pixel_fetch_test;
	import afr_pkg::*;

	localparam int          HALF_PERIOD   = 4;
	localparam int          SETTLE_CYCLES = 12;
	localparam int          HOLD_CYCLES   = 80;
	localparam int          PHASE_ITEMS   = 65;
	localparam int          Q_ONE         = 65536;
	localparam logic [31:0] COEF_MIN      = 32'h8000_0000;
	localparam logic [31:0] COEF_MAX      = 32'h7FFF_FFFF;

	typedef struct {
		int xx, xy, ox, yx, yy, oy;
		int w, h;
	} geometry_t;

	class pixel_scoreboard;
		logic [PIX_W-1:0] frame [DEPTH];
		bit               written [DEPTH];
		int               m_xx, m_xy, m_ox, m_yx, m_yy, m_oy;
		int               width, height;
		out_item_t        awaited [$];
		int               errors;

		function new();
			m_xx = Q_ONE;
			m_xy = 0;
			m_ox = 0;
			m_yx = 0;
			m_yy = Q_ONE;
			m_oy = 0;
			width = MAX_WIDTH;
			height = MAX_HEIGHT;
			errors = 0;
		endfunction

		function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
			case (idx)
				REG_COEF_XX:  m_xx = val;
				REG_COEF_XY:  m_xy = val;
				REG_OFFSET_X: m_ox = val;
				REG_COEF_YX:  m_yx = val;
				REG_COEF_YY:  m_yy = val;
				REG_OFFSET_Y: m_oy = val;
				REG_SRC_W:    width = int'(val[DIM_W-1:0]);
				REG_SRC_H:    height = int'(val[DIM_W-1:0]);
				default: ;
			endcase
		endfunction

		// pixel center is (2p+1)/2, so the sums are exact in units of 2^-17
		function bit maps_inside(input logic [7:0] x, input logic [7:0] y,
				output int sx, output int sy);
			longint hx, hy, acc_x, acc_y;
			int w, h;
			hx = 2 * longint'(x) + 1;
			hy = 2 * longint'(y) + 1;
			acc_x = longint'(m_xx) * hx + longint'(m_xy) * hy + 2 * longint'(m_ox);
			acc_y = longint'(m_yx) * hx + longint'(m_yy) * hy + 2 * longint'(m_oy);
			sx = int'(acc_x >>> FRAC_W);
			sy = int'(acc_y >>> FRAC_W);
			w = (width > MAX_WIDTH) ? MAX_WIDTH : width;
			h = (height > MAX_HEIGHT) ? MAX_HEIGHT : height;
			return sx >= 0 && sy >= 0 && sx < w && sy < h;
		endfunction

		function void note_request(input in_item_t req);
			int sx, sy;
			logic [PIX_W-1:0] pix;
			out_item_t due;
			if (req.command == CMD_STORE) begin
				frame[{req.pos_y, req.pos_x}] = {req.chan3_in, req.chan2_in,
					req.chan1_in, req.chan0_in};
				written[{req.pos_y, req.pos_x}] = 1'b1;
			end else begin
				if (maps_inside(req.pos_x, req.pos_y, sx, sy)) begin
					pix = frame[sy * MAX_WIDTH + sx];
					due.chan0_out = pix[7:0];
					due.chan1_out = pix[15:8];
					due.chan2_out = pix[23:16];
					due.chan3_out = pix[31:24];
					due.outside = 1'b0;
				end else begin
					due.chan0_out = '0;
					due.chan1_out = '0;
					due.chan2_out = '0;
					due.chan3_out = ALPHA_FULL;
					due.outside = 1'b1;
				end
				awaited.push_back(due);
			end
		endfunction

		function void compare(input string field, input logic [7:0] due, input logic [7:0] got);
			if (got !== due) begin
				$error("%s mismatch: expected %0d, got %0d", field, due, got);
				errors++;
			end
		endfunction

		function void check_result(input out_item_t got);
			out_item_t due;
			if (awaited.size() == 0) begin
				$error("fetch result with no request outstanding: %h", got);
				errors++;
				return;
			end
			due = awaited.pop_front();
			compare("chan0_out", due.chan0_out, got.chan0_out);
			compare("chan1_out", due.chan1_out, got.chan1_out);
			compare("chan2_out", due.chan2_out, got.chan2_out);
			compare("chan3_out", due.chan3_out, got.chan3_out);
			compare("outside", 8'(due.outside), 8'(got.outside));
		endfunction

		function int outstanding();
			return awaited.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COEF_W-1:0]    cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_item_t             in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	pixel_scoreboard board;

	affine_rotate_pixel_fetch dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// result side: check, then pick ready for the next edge
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			board.check_result(out_data);
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_request(input in_item_t req);
		// each idle cycle is drawn on its own
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_request(req);
	endtask

	// a fetch that lands on a never-written entry gets a store there first
	task automatic issue(input logic cmd, input logic [7:0] x, input logic [7:0] y,
			input logic [31:0] pix);
		int sx, sy;
		logic [31:0] fill;
		if (cmd == CMD_FETCH && board.maps_inside(x, y, sx, sy)
				&& !board.written[sy * MAX_WIDTH + sx]) begin
			fill = $urandom;
			send_request(in_item_t'{CMD_STORE, sx[7:0], sy[7:0], fill[7:0], fill[15:8],
				fill[23:16], fill[31:24]});
		end
		send_request(in_item_t'{cmd, x, y, pix[7:0], pix[15:8], pix[23:16], pix[31:24]});
	endtask

	// drop valid and wait for every outstanding fetch to come back
	task automatic settle(input int extra);
		in_valid <= 1'b0;
		do @(posedge clk); while (board.outstanding() != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		board.set_reg(idx, val);
	endtask

	task automatic load_geometry(input geometry_t g);
		put_reg(REG_COEF_XX, g.xx);
		put_reg(REG_COEF_XY, g.xy);
		put_reg(REG_OFFSET_X, g.ox);
		put_reg(REG_COEF_YX, g.yx);
		put_reg(REG_COEF_YY, g.yy);
		put_reg(REG_OFFSET_Y, g.oy);
		put_reg(REG_SRC_W, g.w);
		put_reg(REG_SRC_H, g.h);
		cfg_we <= 1'b0;
	endtask

	function automatic int rand_fixed(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	task automatic run_phase(input geometry_t g, input int count, input int profile,
			input bit with_hold, input bit with_pause);
		logic [7:0] x, y;
		logic cmd;
		int send_pct, recv_pct;
		case (profile)
			0: begin send_pct = 0; recv_pct = 0; end
			1: begin send_pct = 69; recv_pct = 0; end
			2: begin send_pct = 0; recv_pct = 69; end
			default: begin send_pct = 11; recv_pct = 11; end
		endcase
		settle(SETTLE_CYCLES);
		load_geometry(g);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		for (int i = 0; i < count; i++) begin
			if (with_hold && i == count / 4) begin
				// receiver blocks while requests keep coming, so the block backs up
				send_idle_pct = 0;
				hold_left <= HOLD_CYCLES;
			end
			if (with_hold && i == count / 4 + 30) send_idle_pct = send_pct;
			if (with_pause && i == count / 2) settle(0);
			cmd = ($urandom_range(99) < 45) ? CMD_STORE : CMD_FETCH;
			if ($urandom_range(3) == 0) begin
				x = 8'($urandom);
				y = 8'($urandom);
			end else begin
				// most traffic near the origin so fetches hit stored pixels
				x = 8'($urandom_range(0, 47));
				y = 8'($urandom_range(0, 47));
			end
			issue(cmd, x, y, $urandom);
		end
	endtask

	initial begin
		geometry_t shapes [10];
		board = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset setting is the identity over the full frame
		issue(CMD_STORE, 8'd0, 8'd0, 32'h0000_0000);
		issue(CMD_STORE, 8'd255, 8'd255, 32'hFFFF_FFFF);
		issue(CMD_STORE, 8'd255, 8'd0, 32'hA55A_5AA5);
		issue(CMD_STORE, 8'd0, 8'd255, 32'h5AA5_A55A);
		issue(CMD_FETCH, 8'd0, 8'd0, 32'hFFFF_FFFF);
		issue(CMD_FETCH, 8'd255, 8'd255, 32'h0000_0000);
		issue(CMD_FETCH, 8'd255, 8'd0, 32'h0000_0000);
		issue(CMD_FETCH, 8'd0, 8'd255, 32'h0000_0000);
		issue(CMD_STORE, 8'd0, 8'd0, 32'hFFFF_FFFF);
		issue(CMD_FETCH, 8'd0, 8'd0, 32'h0000_0000);

		// one pixel shift left, oversized width, single-row frame
		settle(SETTLE_CYCLES);
		load_geometry(geometry_t'{Q_ONE, 0, -Q_ONE, 0, Q_ONE, 0, 511, 1});
		issue(CMD_FETCH, 8'd0, 8'd0, 32'h0);
		issue(CMD_FETCH, 8'd1, 8'd0, 32'h0);
		issue(CMD_FETCH, 8'd255, 8'd0, 32'h0);
		issue(CMD_FETCH, 8'd1, 8'd1, 32'h0);
		issue(CMD_FETCH, 8'd255, 8'd255, 32'h0);

		// extreme coefficients and an empty frame
		settle(SETTLE_CYCLES);
		load_geometry(geometry_t'{COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN,
			COEF_MAX, 0, 0});
		issue(CMD_FETCH, 8'd0, 8'd0, 32'h0);
		issue(CMD_FETCH, 8'd255, 8'd255, 32'h0);
		issue(CMD_FETCH, 8'd128, 8'd64, 32'h0);

		shapes[0] = geometry_t'{0, -Q_ONE, 32 * Q_ONE, Q_ONE, 0, 0, 32, 32};
		shapes[1] = geometry_t'{56756, -32768, 8 * Q_ONE, 32768, 56756, -4 * Q_ONE, 40, 24};
		// every fetch lands on one pixel: stores in between must show up at once
		shapes[2] = geometry_t'{0, 0, 5 * Q_ONE + Q_ONE / 2, 0, 0, 2 * Q_ONE + Q_ONE / 4,
			511, 257};
		shapes[3] = geometry_t'{Q_ONE / 2, 0, 0, 0, Q_ONE / 2, 0, 300, 200};
		shapes[4] = geometry_t'{COEF_MIN, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN,
			256, 256};
		shapes[5] = geometry_t'{Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 256};
		shapes[6] = geometry_t'{Q_ONE, Q_ONE / 4, -3 * Q_ONE - 3 * Q_ONE / 4, -Q_ONE / 8,
			Q_ONE, 5 * Q_ONE / 2, 1, 256};
		for (int k = 7; k < 9; k++) begin
			shapes[k] = geometry_t'{rand_fixed(2 * Q_ONE), rand_fixed(2 * Q_ONE),
				rand_fixed(32 * Q_ONE), rand_fixed(2 * Q_ONE), rand_fixed(2 * Q_ONE),
				rand_fixed(32 * Q_ONE), $urandom_range(1, 48), $urandom_range(1, 48)};
		end
		shapes[9] = geometry_t'{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			256, 0};

		for (int k = 0; k < 10; k++) begin
			run_phase(shapes[k], PHASE_ITEMS, k % 4, k == 2, k % 3 == 1);
		end

		settle(SETTLE_CYCLES);
		if (board.errors == 0 && board.outstanding() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/afr_pkg.sv
rtl/core/afr_ctrl.sv
rtl/core/afr_dpath.sv
rtl/core/affine_rotate_pixel_fetch.sv
verif/affine_rotate_pixel_fetch_test.sv
